// ===== hdl/sbst_pkg.sv =====
// package for the segment / box slab test
// shared constants and the classification flag struct; no dependencies
`default_nettype none

package sbst_pkg;

  // default coordinate width and queue depth
  localparam int COORD_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // classification made by the front part for one request
  typedef struct packed {
    logic inside_hit;  // an endpoint lies in the closed box
    logic par_miss;    // a parallel axis with the start outside its slab
    logic act_x;       // x axis constrains t
    logic act_y;       // y axis constrains t
  } sbst_flags_t;

  localparam int FLAGS_W = $bits(sbst_flags_t);

endpackage

`default_nettype wire

// ===== hdl/sbst_if.sv =====
// valid/ready channel interfaces for the slab test requests and results
// depends on nothing but the coordinate width parameter
`default_nettype none

interface sbst_in_if #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic clk
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;

  modport source (
    input  clk, ready,
    output valid, start_x, start_y, end_x, end_y,
           box_min_x, box_min_y, box_max_x, box_max_y
  );
  modport sink (
    input  clk, valid, start_x, start_y, end_x, end_y,
           box_min_x, box_min_y, box_max_x, box_max_y,
    output ready
  );
endinterface

interface sbst_out_if (
  input wire logic clk
);
  logic valid;
  logic ready;
  logic hit;

  modport source (input clk, ready, output valid, hit);
  modport sink (input clk, valid, hit, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbst_front.sv =====
// front part: accepts a request, runs the endpoint test and sets up slabs
// depends on sbst_pkg and sbst_in_if
`default_nettype none

module sbst_front #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  sbst_in_if.sink                      in_ch,
  output logic                         fr_valid,
  input  wire logic                    fr_ready,
  output sbst_pkg::sbst_flags_t        fr_flags,
  output logic signed [COORD_WIDTH:0]  fr_nx,
  output logic signed [COORD_WIDTH:0]  fr_fx,
  output logic        [COORD_WIDTH:0]  fr_dx,
  output logic signed [COORD_WIDTH:0]  fr_ny,
  output logic signed [COORD_WIDTH:0]  fr_fy,
  output logic        [COORD_WIDTH:0]  fr_dy
);
  import sbst_pkg::*;

  localparam int XW = COORD_WIDTH + 1;

  logic signed [XW-1:0] sx, sy, ex, ey, x0, y0, x1, y1;
  logic signed [XW-1:0] dx, dy;
  logic                 in_s, in_e, out_sx, out_sy;
  sbst_flags_t          flags;
  logic signed [XW-1:0] nx, fx, ny, fy;
  logic        [XW-1:0] mx, my;

  // sign extend by one bit so differences cannot overflow
  assign sx = {in_ch.start_x[COORD_WIDTH-1], in_ch.start_x};
  assign sy = {in_ch.start_y[COORD_WIDTH-1], in_ch.start_y};
  assign ex = {in_ch.end_x[COORD_WIDTH-1], in_ch.end_x};
  assign ey = {in_ch.end_y[COORD_WIDTH-1], in_ch.end_y};
  assign x0 = {in_ch.box_min_x[COORD_WIDTH-1], in_ch.box_min_x};
  assign y0 = {in_ch.box_min_y[COORD_WIDTH-1], in_ch.box_min_y};
  assign x1 = {in_ch.box_max_x[COORD_WIDTH-1], in_ch.box_max_x};
  assign y1 = {in_ch.box_max_y[COORD_WIDTH-1], in_ch.box_max_y};

  assign dx = ex - sx;
  assign dy = ey - sy;

  // endpoint containment and slab membership of the start
  assign out_sx = (sx < x0) || (sx > x1);
  assign out_sy = (sy < y0) || (sy > y1);
  assign in_s   = !out_sx && !out_sy;
  assign in_e   = (x0 <= ex) && (ex <= x1) && (y0 <= ey) && (ey <= y1);

  // near / far numerators over a non-negative denominator
  always_comb begin
    flags.inside_hit = in_s || in_e;
    flags.par_miss   = ((dx == '0) && out_sx) || ((dy == '0) && out_sy);
    flags.act_x      = (dx != '0);
    flags.act_y      = (dy != '0);
    if (dx[XW-1]) begin
      nx = sx - x1;
      fx = sx - x0;
      mx = XW'(-dx);
    end else begin
      nx = x0 - sx;
      fx = x1 - sx;
      mx = dx;
    end
    if (dy[XW-1]) begin
      ny = sy - y1;
      fy = sy - y0;
      my = XW'(-dy);
    end else begin
      ny = y0 - sy;
      fy = y1 - sy;
      my = dy;
    end
  end

  assign in_ch.ready = !fr_valid || fr_ready;

  // output register toward the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_ch.ready) begin
      fr_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      fr_flags <= flags;
      fr_nx    <= nx;
      fr_fx    <= fx;
      fr_dx    <= mx;
      fr_ny    <= ny;
      fr_fy    <= fy;
      fr_dy    <= my;
    end
  end

`ifndef ASSERT_OFF
  // an endpoint inside the box rules out a parallel miss
  a_class_excl: assert property (@(posedge clk) disable iff (rst)
    fr_valid |-> !(fr_flags.inside_hit && fr_flags.par_miss))
    else $error("front: inside hit and parallel miss both set");
`endif

endmodule

`default_nettype wire

// ===== hdl/sbst_queue.sv =====
// short queue between the front and back parts
// depends on nothing but its parameters
`default_nettype none

module sbst_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue: count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue: count lost a push");
`endif

endmodule

`default_nettype wire

// ===== hdl/sbst_back.sv =====
// back part: exact fraction compares by cross products, four stages
// depends on sbst_pkg and sbst_out_if
`default_nettype none

module sbst_back #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    bk_valid,
  output logic                         bk_ready,
  input  wire sbst_pkg::sbst_flags_t   bk_flags,
  input  wire logic signed [COORD_WIDTH:0] bk_nx,
  input  wire logic signed [COORD_WIDTH:0] bk_fx,
  input  wire logic        [COORD_WIDTH:0] bk_dx,
  input  wire logic signed [COORD_WIDTH:0] bk_ny,
  input  wire logic signed [COORD_WIDTH:0] bk_fy,
  input  wire logic        [COORD_WIDTH:0] bk_dy,
  sbst_out_if.source                   out_ch
);
  import sbst_pkg::*;

  localparam int XW = COORD_WIDTH + 1;
  localparam int MW = 2 * XW + 1;

  logic adv;

  // stage 1: cross products of near and far fractions
  logic                 v1;
  sbst_flags_t          f1;
  logic signed [XW-1:0] nx1, fx1, ny1, fy1;
  logic        [XW-1:0] dx1, dy1;
  logic signed [MW-1:0] pa, pb, pc, pd;

  // stage 2: chosen entry and exit fractions
  logic                 v2;
  sbst_flags_t          f2;
  logic signed [XW-1:0] en2, xn2;
  logic        [XW-1:0] ed2, xd2;

  // stage 3: entry against exit, and the t window test
  logic                 v3;
  sbst_flags_t          f3;
  logic signed [MW-1:0] q1, q2;
  logic                 xneg3, tok3;

  assign adv      = !out_ch.valid || out_ch.ready;
  assign bk_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      v1           <= bk_valid;
      v2           <= v1;
      v3           <= v2;
      out_ch.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      f1  <= bk_flags;
      nx1 <= bk_nx;
      fx1 <= bk_fx;
      ny1 <= bk_ny;
      fy1 <= bk_fy;
      dx1 <= bk_dx;
      dy1 <= bk_dy;
      pa  <= bk_nx * $signed({1'b0, bk_dy});
      pb  <= bk_ny * $signed({1'b0, bk_dx});
      pc  <= bk_fx * $signed({1'b0, bk_dy});
      pd  <= bk_fy * $signed({1'b0, bk_dx});

      // stage 2: largest entry, smallest exit
      f2 <= f1;
      priority if (f1.act_x && f1.act_y) begin
        if (pb > pa) begin
          en2 <= ny1;
          ed2 <= dy1;
        end else begin
          en2 <= nx1;
          ed2 <= dx1;
        end
        if (pd < pc) begin
          xn2 <= fy1;
          xd2 <= dy1;
        end else begin
          xn2 <= fx1;
          xd2 <= dx1;
        end
      end else if (f1.act_x) begin
        en2 <= nx1;
        ed2 <= dx1;
        xn2 <= fx1;
        xd2 <= dx1;
      end else if (f1.act_y) begin
        en2 <= ny1;
        ed2 <= dy1;
        xn2 <= fy1;
        xd2 <= dy1;
      end else begin
        en2 <= '0;
        ed2 <= XW'(1);
        xn2 <= '0;
        xd2 <= XW'(1);
      end

      // stage 3
      f3    <= f2;
      q1    <= en2 * $signed({1'b0, xd2});
      q2    <= xn2 * $signed({1'b0, ed2});
      xneg3 <= xn2[XW-1];
      if (en2[XW-1]) begin
        tok3 <= (xn2 > 0) && ({xn2[XW-1], xn2} < $signed({1'b0, xd2}));
      end else begin
        tok3 <= (en2 > 0) && ({en2[XW-1], en2} < $signed({1'b0, ed2}));
      end

      // stage 4: result register
      out_ch.hit <= f3.inside_hit ||
                    (!f3.par_miss && !xneg3 && !(q1 > q2) && tok3);
    end
  end

`ifndef ASSERT_OFF
  a_inside_hits: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && f3.inside_hit) |=> (out_ch.valid && out_ch.hit))
    else $error("back: endpoint inside box did not give a hit");
  a_par_misses: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && f3.par_miss) |=> (out_ch.valid && !out_ch.hit))
    else $error("back: parallel miss gave a hit");
`endif

endmodule

`default_nettype wire

// ===== hdl/segment_box_slab_test.sv =====
// Segment / axis-aligned box intersection in 2D with exact integer math.
// One request is accepted per clock cycle when nothing stalls. Its hit
// result passes through the front register that does the endpoint test
// and slab setup, then the queue storage (there is no bypass, so even an
// empty queue adds a register), then four back stages: near/far cross
// products, entry/exit selection, entry/exit cross product with the t
// window test, and the result register. Throughput is set by the back
// pipeline, which advances whenever its result register is empty or
// being taken; the queue lets the front keep accepting for a few requests
// while the result side is stalled.
// depends on sbst_pkg, sbst_if, sbst_front, sbst_queue, sbst_back
`default_nettype none

module segment_box_slab_test #(
  parameter int COORD_WIDTH = sbst_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = sbst_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  sbst_in_if.sink   in_ch,
  sbst_out_if.source out_ch
);
  import sbst_pkg::*;

  localparam int XW = COORD_WIDTH + 1;
  localparam int QW = FLAGS_W + 6 * XW;

  logic                 fr_valid, fr_ready;
  sbst_flags_t          fr_flags, bk_flags;
  logic signed [XW-1:0] fr_nx, fr_fx, fr_ny, fr_fy;
  logic        [XW-1:0] fr_dx, fr_dy;
  logic signed [XW-1:0] bk_nx, bk_fx, bk_ny, bk_fy;
  logic        [XW-1:0] bk_dx, bk_dy;
  logic                 bk_valid, bk_ready;
  logic [QW-1:0]        q_in, q_out;

  // front part
  sbst_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_flags (fr_flags),
    .fr_nx    (fr_nx),
    .fr_fx    (fr_fx),
    .fr_dx    (fr_dx),
    .fr_ny    (fr_ny),
    .fr_fy    (fr_fy),
    .fr_dy    (fr_dy)
  );

  // queue between the parts
  assign q_in = {fr_flags, fr_nx, fr_fx, fr_dx, fr_ny, fr_fy, fr_dy};
  assign {bk_flags, bk_nx, bk_fx, bk_dx, bk_ny, bk_fy, bk_dy} = q_out;

  sbst_queue #(.DATA_W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (q_in),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (q_out)
  );

  // back part
  sbst_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .bk_valid (bk_valid),
    .bk_ready (bk_ready),
    .bk_flags (bk_flags),
    .bk_nx    (bk_nx),
    .bk_fx    (bk_fx),
    .bk_dx    (bk_dx),
    .bk_ny    (bk_ny),
    .bk_fy    (bk_fy),
    .bk_dy    (bk_dy),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench for segment_box_slab_test: directed table, then random requests
// depends on sbst_pkg, sbst_if and the block itself
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = 16;
  localparam int RANDOM_REQS = 1150;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t sx, sy, ex, ey, x0, y0, x1, y1;
  } seg_req_t;
  // directed row: request plus optional typed-in answer
  typedef struct {
    seg_req_t req;
    bit       known;
    bit       hit;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   cycles = 0;
  int   hits_seen = 0;
  int   results_seen = 0;
  bit   expected_hits[$];

  sbst_in_if #(.COORD_WIDTH(CW)) in_ch (.clk(clk));
  sbst_out_if out_ch (.clk(clk));

  segment_box_slab_test #(.COORD_WIDTH(CW)) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sign of an/ad - bn/bd, both denominators positive, exact
  function automatic int frac_sign(longint an, longint ad, longint bn, longint bd);
    logic signed [127:0] l, r;
    l = 128'(signed'(an)) * 128'(signed'(bd));
    r = 128'(signed'(bn)) * 128'(signed'(ad));
    return (l > r) ? 1 : (l < r) ? -1 : 0;
  endfunction

  // does the segment touch the closed box
  function automatic bit segment_hits_box(seg_req_t q);
    longint s[2], e[2], lo[2], hi[2];
    longint en, ed, xn, xd, nn, fn, dd, d, tn, td;
    bit any;
    s[0] = q.sx; s[1] = q.sy; e[0] = q.ex; e[1] = q.ey;
    lo[0] = q.x0; lo[1] = q.y0; hi[0] = q.x1; hi[1] = q.y1;
    en = 0; ed = 1; xn = 0; xd = 1; any = 0;
    if ((lo[0] <= s[0] && s[0] <= hi[0] && lo[1] <= s[1] && s[1] <= hi[1]) ||
        (lo[0] <= e[0] && e[0] <= hi[0] && lo[1] <= e[1] && e[1] <= hi[1]))
      return 1'b1;
    for (int k = 0; k < 2; k++) begin
      d = e[k] - s[k];
      // parallel slab: start must lie inside it
      if (d == 0) begin
        if (s[k] < lo[k] || s[k] > hi[k]) return 1'b0;
        continue;
      end
      if (d > 0) begin
        nn = lo[k] - s[k]; fn = hi[k] - s[k]; dd = d;
      end else begin
        nn = s[k] - hi[k]; fn = s[k] - lo[k]; dd = -d;
      end
      if (!any) begin
        en = nn; ed = dd; xn = fn; xd = dd; any = 1;
      end else begin
        if (frac_sign(nn, dd, en, ed) > 0) begin en = nn; ed = dd; end
        if (frac_sign(fn, dd, xn, xd) < 0) begin xn = fn; xd = dd; end
      end
    end
    if (xn < 0 || frac_sign(en, ed, xn, xd) > 0) return 1'b0;
    if (en < 0) begin tn = xn; td = xd; end else begin tn = en; td = ed; end
    return (tn > 0 && tn < td);
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic coord_t rand_coord(bit narrow);
    if (narrow) return coord_t'($urandom_range(64) - 32);
    return coord_t'($urandom());
  endfunction

  // random query: mostly small boxes near short segments, some full range
  function automatic seg_req_t rand_req();
    seg_req_t q;
    coord_t a, b;
    bit narrow;
    narrow = ($urandom_range(3) != 0);
    q.sx = rand_coord(narrow); q.sy = rand_coord(narrow);
    q.ex = rand_coord(narrow); q.ey = rand_coord(narrow);
    if ($urandom_range(7) == 0) q.ex = q.sx;
    if ($urandom_range(7) == 0) q.ey = q.sy;
    a = rand_coord(narrow); b = rand_coord(narrow);
    q.x0 = (a < b) ? a : b; q.x1 = (a < b) ? b : a;
    a = rand_coord(narrow); b = rand_coord(narrow);
    q.y0 = (a < b) ? a : b; q.y1 = (a < b) ? b : a;
    // occasionally leave a box inverted
    if ($urandom_range(19) == 0) begin a = q.x0; q.x0 = q.x1; q.x1 = a; end
    return q;
  endfunction

  // result side: stall on its own pattern, check in order
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(3) != 0);
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_hits.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          if (out_ch.hit !== expected_hits[0])
            report($sformatf("hit %b, expected %b", out_ch.hit, expected_hits[0]));
          if (out_ch.hit === 1'b1) hits_seen <= hits_seen + 1;
          void'(expected_hits.pop_front());
        end
      end
    end
  end

  // drive one request, holding it until taken
  task automatic send(seg_req_t q, bit known, bit hit);
    bit exp_hit;
    exp_hit = segment_hits_box(q);
    if (known && exp_hit != hit)
      report($sformatf("predictor gives %b on a row typed %b", exp_hit, hit));
    in_ch.valid <= 1'b1;
    in_ch.start_x <= q.sx; in_ch.start_y <= q.sy;
    in_ch.end_x <= q.ex; in_ch.end_y <= q.ey;
    in_ch.box_min_x <= q.x0; in_ch.box_min_y <= q.y0;
    in_ch.box_max_x <= q.x1; in_ch.box_max_y <= q.y1;
    do @(posedge clk); while (!in_ch.ready);
    expected_hits.push_back(known ? hit : exp_hit);
  endtask

  task automatic idle_cycles(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic seg_req_t mk(int sx, sy, ex, ey, x0, y0, x1, y1);
    seg_req_t q;
    q.sx = coord_t'(sx); q.sy = coord_t'(sy); q.ex = coord_t'(ex); q.ey = coord_t'(ey);
    q.x0 = coord_t'(x0); q.y0 = coord_t'(y0); q.x1 = coord_t'(x1); q.y1 = coord_t'(y1);
    return q;
  endfunction

  dir_row_t directed[$];

  initial begin
    int burst;
    in_ch.valid = 1'b0;
    {in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y} = '0;
    {in_ch.box_min_x, in_ch.box_min_y, in_ch.box_max_x, in_ch.box_max_y} = '0;
    out_ch.ready = 1'b0;
    // endpoint inside, other endpoint inside, crossing, misses
    directed.push_back('{mk(0, 0, 50, 50, -1, -1, 1, 1), 1, 1});
    directed.push_back('{mk(50, 50, 0, 0, -1, -1, 1, 1), 1, 1});
    directed.push_back('{mk(-10, 0, 10, 0, -1, -1, 1, 1), 1, 1});
    directed.push_back('{mk(-10, 5, 10, 5, -1, -1, 1, 1), 1, 0});
    // parallel slab with start outside, degenerate point outside and inside
    directed.push_back('{mk(5, -10, 5, 10, -1, -1, 1, 1), 1, 0});
    directed.push_back('{mk(7, 7, 7, 7, -1, -1, 1, 1), 1, 0});
    directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, 1});
    // inverted box
    directed.push_back('{mk(-10, 0, 10, 0, 1, -1, -1, 1), 1, 0});
    // corner graze, segment pointing away, stopping short
    directed.push_back('{mk(-2, 0, 0, 2, -1, -1, 1, 1), 0, 0});
    directed.push_back('{mk(5, 0, 10, 0, -1, -1, 1, 1), 1, 0});
    directed.push_back('{mk(-10, 0, -5, 0, -1, -1, 1, 1), 1, 0});
    // extremes of the coordinate range, then small diagonal segments
    directed.push_back('{mk(-32768, -32768, 32767, 32767, -1, -1, 1, 1), 1, 1});
    directed.push_back('{mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767), 1, 1});
    directed.push_back('{mk(-32768, 32767, 32767, -32768, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(-32768, 0, 32767, 1, 100, 100, 32767, 32767), 0, 0});
    directed.push_back('{mk(-32768, -32768, -32768, 32767, -32767, -32768, 32767, 32767), 1, 0});
    directed.push_back('{mk(-3, 1, 3, -1, -1, -1, 1, 1), 0, 0});
    directed.push_back('{mk(-3, 2, 3, -2, 0, 0, 1, 1), 0, 0});
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send(directed[i].req, directed[i].known, directed[i].hit);
    idle_cycles(2);
    // random bursts with gaps, some back to back
    for (int n = 0; n < RANDOM_REQS; ) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && n < RANDOM_REQS; j++, n++) send(rand_req(), 0, 0);
      if ($urandom_range(2) != 0) idle_cycles($urandom_range(1, 6));
    end
    in_ch.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("requests checked: %0d results, %0d of them hits", results_seen, hits_seen);
    $display("covered: directed slab corner cases and random segments incl. full range");
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

endmodule
